// ===== rtl/core/anc_pkg.sv =====
// shared types, constants and the step scale table of the adpcm nibble codec
`timescale 1ns / 1ps
package anc_pkg;

    localparam logic [14:0] STEP_MIN  = 15'd127;
    localparam logic [14:0] STEP_MAX  = 15'd24576;
    localparam logic [10:0] DECAY_MUL = 11'd254;

    typedef enum logic [1:0] {
        MAC_DECAY,
        MAC_INC,
        MAC_SCALE
    } mac_op_t;

    typedef struct packed {
        mac_op_t     op;
        logic [2:0]  mag;
    } mac_ctrl_t;

    function automatic logic [10:0] scale_tab(input logic [2:0] mag);
        logic [10:0] val;
        unique case (mag)
            3'd4:    val = 11'd307;
            3'd5:    val = 11'd409;
            3'd6:    val = 11'd512;
            3'd7:    val = 11'd614;
            default: val = 11'd230;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/anc_if.sv =====
// valid/ready stream interfaces for the input and result channels
`timescale 1ns / 1ps
interface anc_in_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic signed [15:0] data_in;

    modport source (output valid, output start_req, output data_in, input ready);
    modport sink (input valid, input start_req, input data_in, output ready);
endinterface

interface anc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] data_out;
    logic               last;

    modport source (output valid, output data_out, output last, input ready);
    modport sink (input valid, input data_out, input last, output ready);
endinterface

// ===== rtl/core/anc_mac.sv =====
// shared multiplier with operand select and registered product
`timescale 1ns / 1ps
module anc_mac
(
    input  logic                clk,
    input  anc_pkg::mac_ctrl_t  ctrl,
    input  logic signed [15:0]  pred,
    input  logic        [14:0]  step,
    output logic signed [27:0]  prod
);

    logic signed [16:0] op_a;
    logic signed [10:0] op_b;
    logic signed [27:0] prod_reg;

    always_comb
    begin
        unique case (ctrl.op)
            anc_pkg::MAC_DECAY:
            begin
                op_a = {pred[15], pred};
                op_b = anc_pkg::DECAY_MUL;
            end
            anc_pkg::MAC_INC:
            begin
                op_a = {2'b00, step};
                op_b = {7'd0, ctrl.mag, 1'b1};
            end
            anc_pkg::MAC_SCALE:
            begin
                op_a = {2'b00, step};
                op_b = anc_pkg::scale_tab(ctrl.mag);
            end
            default:
            begin
                op_a = {2'b00, step};
                op_b = anc_pkg::DECAY_MUL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 28'(op_a * op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/adpcm_nibble_codec_top.sv =====
// top level: sequencer, codec state and output register of the adpcm nibble codec
//
//  channel   dir  handshake               payload
//  in_ch     in   valid / ready           start_req, data_in[15:0]
//  out_ch    out  valid / ready           data_out[15:0], last
//  cfg       in   cfg_we (no handshake)   cfg_wdata = mode
//
//  one item at a time; in_ch.ready is high only while idle
//  decode: accept, then per nibble (high first) the decay, increment, scale and update
//  states on the shared multiplier, then emit; encode: accept, a saturation check, a
//  bitwise quotient search unless saturated, the same states, and an emit every second sample
//  a stalled out_ch holds the sequencer in its emit state
//  reset: predictor 0, step 127, nibble phase 0, held code 0, mode decode
`timescale 1ns / 1ps
module adpcm_nibble_codec_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    anc_in_if.sink             in_ch,
    anc_out_if.source          out_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QSAT,
        S_QDIV,
        S_DECAY,
        S_INC,
        S_SCALE,
        S_UPD,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic signed [15:0]  pred_reg, pred_next;
    logic        [14:0]  step_reg, step_next;
    logic                phase_reg, phase_next;
    logic        [3:0]   held_reg, held_next;
    logic        [3:0]   code_reg, code_next;
    logic        [3:0]   low_nib_reg, low_nib_next;
    logic                second_reg, second_next;
    logic        [17:0]  rem_reg, rem_next;
    logic        [1:0]   bit_reg, bit_next;
    logic signed [15:0]  decay_reg, decay_next;
    logic        [15:0]  inc_reg, inc_next;
    logic signed [15:0]  out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    anc_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [27:0]  prod;

    logic                accept;
    logic signed [15:0]  pred_use;
    logic        [15:0]  diff;
    logic        [15:0]  mag;
    logic        [17:0]  dvs;
    logic signed [27:0]  adj;
    logic signed [17:0]  sum;
    logic        [15:0]  ns;
    logic                slot_free;

    anc_mac u_mac
    (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .pred (pred_reg),
        .step (step_reg),
        .prod (prod)
    );

    assign accept    = in_ch.valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        mac_ctrl.mag = code_reg[2:0];
        unique case (state_reg)
            S_INC:   mac_ctrl.op = anc_pkg::MAC_INC;
            S_SCALE: mac_ctrl.op = anc_pkg::MAC_SCALE;
            default: mac_ctrl.op = anc_pkg::MAC_DECAY;
        endcase
    end

    // quantizer front end and update arithmetic
    always_comb
    begin
        pred_use = in_ch.start_req ? 16'sd0 : pred_reg;
        diff     = {in_ch.data_in[15:3], 3'b000} - pred_use;
        mag      = diff[15] ? (16'd0 - diff) : diff;
        dvs      = {3'b000, step_reg} << bit_reg;
        adj      = prod + (prod[27] ? 28'sd255 : 28'sd0);
        sum      = code_reg[3] ? ({{2{decay_reg[15]}}, decay_reg} - {2'b00, inc_reg})
                               : ({{2{decay_reg[15]}}, decay_reg} + {2'b00, inc_reg});
        ns       = prod[23:8];
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        pred_next      = pred_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        code_next      = code_reg;
        low_nib_next   = low_nib_reg;
        second_next    = second_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        decay_next     = decay_reg;
        inc_next       = inc_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.start_req)
                    begin
                        pred_next  = 16'sd0;
                        step_next  = anc_pkg::STEP_MIN;
                        phase_next = 1'b0;
                        held_next  = 4'd0;
                    end
                    second_next  = 1'b0;
                    low_nib_next = in_ch.data_in[3:0];
                    if (mode_reg)
                    begin
                        code_next  = {diff[15], 3'b000};
                        rem_next   = {mag, 2'b00};
                        state_next = S_QSAT;
                    end
                    else
                    begin
                        code_next  = in_ch.data_in[7:4];
                        state_next = S_DECAY;
                    end
                end
            end
            S_QSAT:
            begin
                bit_next = 2'd2;
                if (rem_reg >= {step_reg, 3'b000})
                begin
                    code_next[2:0] = 3'd7;
                    state_next     = S_DECAY;
                end
                else
                begin
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (rem_reg >= dvs)
                begin
                    rem_next           = rem_reg - dvs;
                    code_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 2'd1;
                if (bit_reg == 2'd0)
                begin
                    state_next = S_DECAY;
                end
            end
            S_DECAY:
            begin
                state_next = S_INC;
            end
            S_INC:
            begin
                decay_next = adj[23:8];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                inc_next   = prod[18:3];
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (sum > 18'sd32767)
                begin
                    pred_next = 16'sh7fff;
                end
                else if (sum < -18'sd32768)
                begin
                    pred_next = 16'sh8000;
                end
                else
                begin
                    pred_next = sum[15:0];
                end
                if (ns < {1'b0, anc_pkg::STEP_MIN})
                begin
                    step_next = anc_pkg::STEP_MIN;
                end
                else if (ns > {1'b0, anc_pkg::STEP_MAX})
                begin
                    step_next = anc_pkg::STEP_MAX;
                end
                else
                begin
                    step_next = ns[14:0];
                end
                if (mode_reg && !phase_reg)
                begin
                    held_next  = code_reg;
                    phase_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (mode_reg)
                    begin
                        phase_next = 1'b0;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = mode_reg || second_reg;
                    out_data_next  = mode_reg ? {8'd0, held_reg, code_reg} : pred_reg;
                    if (!mode_reg && !second_reg)
                    begin
                        second_next = 1'b1;
                        code_next   = low_nib_reg;
                        state_next  = S_DECAY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            pred_reg      <= 16'sd0;
            step_reg      <= anc_pkg::STEP_MIN;
            phase_reg     <= 1'b0;
            held_reg      <= 4'd0;
            second_reg    <= 1'b0;
            bit_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pred_reg      <= pred_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            second_reg    <= second_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        low_nib_reg  <= low_nib_next;
        rem_reg      <= rem_next;
        decay_reg    <= decay_next;
        inc_reg      <= inc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = out_data_reg;
    assign out_ch.last     = out_last_reg;

endmodule

// ===== rtl/core/anc_checker.sv =====
// port-level checks on the adpcm nibble codec, bound to the top level
`timescale 1ns / 1ps
module anc_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               out_last,
    input  logic signed [15:0] out_data
);

    // one item at a time: no new beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // a first decoded sample means the item is still in flight
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> !in_ready)
        else $error("ready while an item has results left");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data) && $stable(out_last)))
        else $error("stalled result beat changed");

endmodule

bind adpcm_nibble_codec_top anc_checker u_anc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last),
    .out_data  (out_ch.data_out)
);
